FILE: rtl/lsbs_pkg.sv
// Shared types and constants for the status LED blink sequencer.
// No dependencies; the files that use it refer to this package by scoped names.
package lsbs_pkg;

    // Tick counter width default, overridable from the top level
    localparam int TICK_COUNT_WIDTH_DEFAULT = 16;

    // Configuration port geometry
    localparam int CFG_ADDR_WIDTH = 5;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int CFG_REG_WIDTH  = 16;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_STANDBY_PERIOD   = 3'd0;
    localparam logic [2:0] REG_MEASURING_PERIOD = 3'd1;
    localparam logic [2:0] REG_PULSE_ON         = 3'd2;
    localparam logic [2:0] REG_PULSE_GAP        = 3'd3;
    localparam logic [2:0] REG_PATTERN_PAUSE    = 3'd4;
    localparam logic [2:0] REG_BUILTIN_ENABLE   = 3'd5;
    localparam logic [2:0] REG_EXTERNAL_ENABLE  = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_STANDBY_PERIOD   = 16'd1000;
    localparam logic [15:0] RST_MEASURING_PERIOD = 16'd100;
    localparam logic [15:0] RST_PULSE_ON         = 16'd150;
    localparam logic [15:0] RST_PULSE_GAP        = 16'd150;
    localparam logic [15:0] RST_PATTERN_PAUSE    = 16'd2000;
    localparam logic        RST_BUILTIN_ENABLE   = 1'b1;
    localparam logic        RST_EXTERNAL_ENABLE  = 1'b0;

    // Input operation codes; code 3 is unused and ignored
    localparam logic [1:0] OP_TICK        = 2'd0;
    localparam logic [1:0] OP_SET_MODE    = 2'd1;
    localparam logic [1:0] OP_LINK_STATUS = 2'd2;

    // Pulse counts of the coded patterns
    localparam logic [2:0] PULSES_LINK_LOST = 3'd2;
    localparam logic [2:0] PULSES_READING   = 3'd3;

    typedef enum logic [1:0] {
        MODE_STANDBY   = 2'd0,
        MODE_LINK_LOST = 2'd1,
        MODE_READING   = 2'd2,
        MODE_MEASURING = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ON    = 2'd1,
        PH_GAP   = 2'd2,
        PH_OFF   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [15:0] standby_period;
        logic [15:0] measuring_period;
        logic [15:0] pulse_on_ticks;
        logic [15:0] pulse_gap_ticks;
        logic [15:0] pattern_pause_ticks;
        logic        builtin_enable;
        logic        external_enable;
    } cfg_t;

endpackage

FILE: rtl/lsbs_if.sv
// Valid/ready channel interfaces for the sequencer's input and result items.
// Depends on nothing; payload widths are fixed by the item format.
interface lsbs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [1:0] new_mode;
    logic       link_up;

    modport source (output valid, output op, output new_mode, output link_up, input ready);
    modport sink   (input valid, input op, input new_mode, input link_up, output ready);
endinterface

interface lsbs_out_if;
    logic       valid;
    logic       ready;
    logic       led_primary;
    logic       led_secondary;
    logic [1:0] mode_now;

    modport source (output valid, output led_primary, output led_secondary,
                    output mode_now, input ready);
    modport sink   (input valid, input led_primary, input led_secondary,
                    input mode_now, output ready);
endinterface

FILE: rtl/lsbs_cfg_regs.sv
// APB-style configuration register file for the blink sequencer.
// Depends on lsbs_pkg for register indexes, reset values and cfg_t.
module lsbs_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsbs_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [lsbs_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [lsbs_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output lsbs_pkg::cfg_t                       cfg
);

    lsbs_pkg::cfg_t cfg_reg;
    lsbs_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                lsbs_pkg::REG_STANDBY_PERIOD:   cfg_next.standby_period      = pwdata[15:0];
                lsbs_pkg::REG_MEASURING_PERIOD: cfg_next.measuring_period    = pwdata[15:0];
                lsbs_pkg::REG_PULSE_ON:         cfg_next.pulse_on_ticks      = pwdata[15:0];
                lsbs_pkg::REG_PULSE_GAP:        cfg_next.pulse_gap_ticks     = pwdata[15:0];
                lsbs_pkg::REG_PATTERN_PAUSE:    cfg_next.pattern_pause_ticks = pwdata[15:0];
                lsbs_pkg::REG_BUILTIN_ENABLE:   cfg_next.builtin_enable      = pwdata[0];
                lsbs_pkg::REG_EXTERNAL_ENABLE:  cfg_next.external_enable     = pwdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.standby_period      <= lsbs_pkg::RST_STANDBY_PERIOD;
            cfg_reg.measuring_period    <= lsbs_pkg::RST_MEASURING_PERIOD;
            cfg_reg.pulse_on_ticks      <= lsbs_pkg::RST_PULSE_ON;
            cfg_reg.pulse_gap_ticks     <= lsbs_pkg::RST_PULSE_GAP;
            cfg_reg.pattern_pause_ticks <= lsbs_pkg::RST_PATTERN_PAUSE;
            cfg_reg.builtin_enable      <= lsbs_pkg::RST_BUILTIN_ENABLE;
            cfg_reg.external_enable     <= lsbs_pkg::RST_EXTERNAL_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            lsbs_pkg::REG_STANDBY_PERIOD:   prdata[15:0] = cfg_reg.standby_period;
            lsbs_pkg::REG_MEASURING_PERIOD: prdata[15:0] = cfg_reg.measuring_period;
            lsbs_pkg::REG_PULSE_ON:         prdata[15:0] = cfg_reg.pulse_on_ticks;
            lsbs_pkg::REG_PULSE_GAP:        prdata[15:0] = cfg_reg.pulse_gap_ticks;
            lsbs_pkg::REG_PATTERN_PAUSE:    prdata[15:0] = cfg_reg.pattern_pause_ticks;
            lsbs_pkg::REG_BUILTIN_ENABLE:   prdata[0]    = cfg_reg.builtin_enable;
            lsbs_pkg::REG_EXTERNAL_ENABLE:  prdata[0]    = cfg_reg.external_enable;
            default: ;
        endcase
    end

endmodule

FILE: rtl/lsbs_core.sv
// Mode/override tracking, pattern phase sequencer and result register.
// Depends on lsbs_pkg and the channel interfaces in lsbs_if.sv.
module lsbs_core #(
    parameter int TICK_COUNT_WIDTH = lsbs_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lsbs_pkg::cfg_t  cfg,
    lsbs_in_if.sink         in_ch,
    lsbs_out_if.source      out_ch
);

    localparam logic [32:0] MaxTicks = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;
    localparam logic [TICK_COUNT_WIDTH-1:0] OneTick = TICK_COUNT_WIDTH'(1);

    // Zero lasts one tick; too long saturates to the counter maximum
    function automatic logic [TICK_COUNT_WIDTH-1:0] clamp_dur(input logic [15:0] d);
        logic [32:0] wide;
        wide = {17'd0, d};
        if (d == 16'd0)
            wide = 33'd1;
        if (wide > MaxTicks)
            wide = MaxTicks;
        return wide[TICK_COUNT_WIDTH-1:0];
    endfunction

    // Mode state
    lsbs_pkg::mode_t requested_mode_reg, requested_mode_next;
    lsbs_pkg::mode_t saved_mode_reg, saved_mode_next;
    logic            override_reg, override_next;
    lsbs_pkg::mode_t running_mode_reg, running_mode_next;

    // Pattern state
    lsbs_pkg::phase_t              phase_reg, phase_next;
    logic [1:0]                    pulse_index_reg, pulse_index_next;
    logic [TICK_COUNT_WIDTH-1:0]   ticks_left_reg, ticks_left_next;
    logic                          led_level_reg, led_level_next;

    // Result register
    logic            out_valid_reg, out_valid_next;
    logic            led_primary_reg, led_secondary_reg;
    logic [1:0]      mode_now_reg;

    // Clamped durations, precomputed from configuration
    logic [TICK_COUNT_WIDTH-1:0] dur_standby, dur_measuring, dur_on, dur_gap, dur_pause;

    logic accept;

    // Working values inside the tick update
    lsbs_pkg::phase_t            cur_phase;
    lsbs_pkg::mode_t             cur_mode;
    logic [1:0]                  cur_idx;
    logic [TICK_COUNT_WIDTH-1:0] cur_left;
    logic [TICK_COUNT_WIDTH-1:0] left_dec;
    logic                        cur_blink;
    logic [2:0]                  pulses;

    assign dur_standby   = clamp_dur({1'b0, cfg.standby_period[15:1]});
    assign dur_measuring = clamp_dur({1'b0, cfg.measuring_period[15:1]});
    assign dur_on        = clamp_dur(cfg.pulse_on_ticks);
    assign dur_gap       = clamp_dur(cfg.pulse_gap_ticks);
    assign dur_pause     = clamp_dur(cfg.pattern_pause_ticks);

    // Result register frees when empty or being taken
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        requested_mode_next = requested_mode_reg;
        saved_mode_next     = saved_mode_reg;
        override_next       = override_reg;
        running_mode_next   = running_mode_reg;
        phase_next          = phase_reg;
        pulse_index_next    = pulse_index_reg;
        ticks_left_next     = ticks_left_reg;
        led_level_next      = led_level_reg;

        cur_phase = phase_reg;
        cur_mode  = running_mode_reg;
        cur_idx   = pulse_index_reg;
        cur_left  = ticks_left_reg;
        left_dec  = ticks_left_reg;
        cur_blink = 1'b0;
        pulses    = lsbs_pkg::PULSES_READING;

        if (accept)
        begin
            case (in_ch.op)
                lsbs_pkg::OP_TICK:
                begin
                    // New pattern: sample requested mode, enter first on phase
                    if (phase_reg == lsbs_pkg::PH_START)
                    begin
                        cur_mode  = requested_mode_reg;
                        cur_idx   = 2'd0;
                        cur_phase = lsbs_pkg::PH_ON;
                        case (requested_mode_reg)
                            lsbs_pkg::MODE_STANDBY:   cur_left = dur_standby;
                            lsbs_pkg::MODE_MEASURING: cur_left = dur_measuring;
                            default:                  cur_left = dur_on;
                        endcase
                    end
                    cur_blink = (cur_mode == lsbs_pkg::MODE_STANDBY) ||
                                (cur_mode == lsbs_pkg::MODE_MEASURING);
                    pulses    = (cur_mode == lsbs_pkg::MODE_LINK_LOST) ?
                                lsbs_pkg::PULSES_LINK_LOST : lsbs_pkg::PULSES_READING;
                    left_dec  = cur_left - OneTick;

                    running_mode_next = cur_mode;
                    phase_next        = cur_phase;
                    pulse_index_next  = cur_idx;
                    ticks_left_next   = left_dec;
                    led_level_next    = (cur_phase == lsbs_pkg::PH_ON);

                    if (left_dec == '0)
                    begin
                        case (cur_phase)
                            lsbs_pkg::PH_ON:
                            begin
                                led_level_next = 1'b0;
                                if (cur_blink)
                                begin
                                    phase_next      = lsbs_pkg::PH_OFF;
                                    ticks_left_next = (cur_mode == lsbs_pkg::MODE_STANDBY) ?
                                                      dur_standby : dur_measuring;
                                end
                                else if (({1'b0, cur_idx} + 3'd1) < pulses)
                                begin
                                    phase_next      = lsbs_pkg::PH_GAP;
                                    ticks_left_next = dur_gap;
                                end
                                else
                                begin
                                    phase_next      = lsbs_pkg::PH_OFF;
                                    ticks_left_next = dur_pause;
                                end
                            end
                            lsbs_pkg::PH_GAP:
                            begin
                                pulse_index_next = cur_idx + 2'd1;
                                phase_next       = lsbs_pkg::PH_ON;
                                ticks_left_next  = dur_on;
                                led_level_next   = 1'b1;
                            end
                            default:
                            begin
                                phase_next       = lsbs_pkg::PH_START;
                                pulse_index_next = 2'd0;
                                ticks_left_next  = '0;
                                led_level_next   = 1'b0;
                            end
                        endcase
                    end
                end
                lsbs_pkg::OP_SET_MODE:
                begin
                    requested_mode_next = lsbs_pkg::mode_t'(in_ch.new_mode);
                end
                lsbs_pkg::OP_LINK_STATUS:
                begin
                    if (!in_ch.link_up)
                    begin
                        if (requested_mode_reg != lsbs_pkg::MODE_LINK_LOST)
                        begin
                            saved_mode_next     = requested_mode_reg;
                            override_next       = 1'b1;
                            requested_mode_next = lsbs_pkg::MODE_LINK_LOST;
                        end
                    end
                    else if (override_reg)
                    begin
                        override_next       = 1'b0;
                        requested_mode_next = saved_mode_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    // Pattern phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= lsbs_pkg::PH_START;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_mode_reg <= lsbs_pkg::MODE_STANDBY;
            saved_mode_reg     <= lsbs_pkg::MODE_STANDBY;
            override_reg       <= 1'b0;
            running_mode_reg   <= lsbs_pkg::MODE_STANDBY;
            pulse_index_reg    <= 2'd0;
            ticks_left_reg     <= '0;
            led_level_reg      <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            requested_mode_reg <= requested_mode_next;
            saved_mode_reg     <= saved_mode_next;
            override_reg       <= override_next;
            running_mode_reg   <= running_mode_next;
            pulse_index_reg    <= pulse_index_next;
            ticks_left_reg     <= ticks_left_next;
            led_level_reg      <= led_level_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Result payload, loaded on each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            led_primary_reg   <= led_level_next & cfg.builtin_enable;
            led_secondary_reg <= led_level_next & cfg.external_enable;
            mode_now_reg      <= requested_mode_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.led_primary   = led_primary_reg;
    assign out_ch.led_secondary = led_secondary_reg;
    assign out_ch.mode_now      = mode_now_reg;

    // LED is lit exactly in on phases
    a_level_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        led_level_reg == (phase_reg == lsbs_pkg::PH_ON))
        else $error("LED level out of step with pattern phase");

    // Only the start phase may hold an empty tick count
    a_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != lsbs_pkg::PH_START) |-> (ticks_left_reg != '0))
        else $error("active phase with zero ticks left");

    // Pulse index stays within the longest coded pattern
    a_pulse_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_index_reg != 2'd3) &&
        ((phase_reg != lsbs_pkg::PH_START) || (pulse_index_reg == 2'd0)))
        else $error("pulse index out of range");

    // Running mode changes only when a new pattern begins
    a_mode_sampled_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        (running_mode_reg != $past(running_mode_reg)) |->
        ($past(phase_reg) == lsbs_pkg::PH_START))
        else $error("running mode changed mid-pattern");

endmodule

FILE: rtl/led_status_blink_sequencer.sv
// Top level of the status LED blink sequencer: config registers plus core.
// Depends on lsbs_pkg, lsbs_if.sv, lsbs_cfg_regs and lsbs_core.
//
// Usage:
//   in_ch  carries one item per transfer: op 0 is a millisecond tick, op 1
//          sets the requested mode, op 2 reports link status (op 3 ignored).
//   out_ch returns exactly one result per input item, in order: the two LED
//          levels (gated by their enables) and the requested mode.
//   APB    seven registers at byte addresses 0..24 (4 * index); write in a
//          setup + access cycle, pready tied high, reads return the value.
// Results: the result of an item is registered and presented the cycle after its transfer.
// Throughput: one item per clock when not stalled; the whole update is one
//   pass of counter and flag logic from accepted item to result register.
// Stalls: in_ch.ready drops only while a result is held and out_ch.ready is
//   low; the held result stays put and the next item waits on the input.
// Reset: rst_n clears mode to standby, drops any link override, parks the
//   pattern at its start phase with the LED off, and loads register
//   defaults; no clearing pass, items are taken once rst_n is released.
module led_status_blink_sequencer #(
    parameter int TICK_COUNT_WIDTH = lsbs_pkg::TICK_COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lsbs_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
    input  logic [lsbs_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
    output logic [lsbs_pkg::CFG_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    lsbs_in_if.sink                              in_ch,
    lsbs_out_if.source                           out_ch
);

    // Live configuration; the user must change it only while the block is idle, which the block itself does not enforce
    lsbs_pkg::cfg_t cfg;

    lsbs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Mode tracking, phase sequencer and one-deep result register
    lsbs_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for led_status_blink_sequencer: random and directed items
// against a local pattern predictor. Needs lsbs_pkg, lsbs_if.sv and the sequencer RTL.
`timescale 1ns / 100ps

module tb_top;

    // Op code 3 has no function; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles with no transfer on either channel before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // Receiver hold-off that backs up the block and stalls its input
    localparam int LONG_HOLD_CYCLES = 120;

    typedef enum int {
        IDLE_SEND_LIGHT,    // sender idles 23%, receiver 78%
        IDLE_SEND_HEAVY,    // sender idles 78%, receiver 23%
        IDLE_NONE
    } idle_plan_t;

    // One input item; drain asks the driver to hold it until all results are back
    typedef struct packed {
        logic [1:0]      op;
        lsbs_pkg::mode_t new_mode;
        logic            link_up;
        logic            drain;
    } led_item_t;

    typedef struct packed {
        logic       led_primary;
        logic       led_secondary;
        logic [1:0] mode_now;
    } led_status_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // APB side
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [lsbs_pkg::CFG_ADDR_WIDTH-1:0] paddr   = '0;
    logic [lsbs_pkg::CFG_DATA_WIDTH-1:0] pwdata  = '0;
    logic [lsbs_pkg::CFG_DATA_WIDTH-1:0] prdata;
    logic                                pready;

    lsbs_in_if  in_ch ();
    lsbs_out_if out_ch ();

    led_status_blink_sequencer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Stimulus and scoreboard storage
    // ------------------------------------------------------------------
    led_item_t   item_q[$];      // items waiting for the driver
    led_status_t status_q[$];    // predicted results, oldest first

    idle_plan_t idle_plan      = IDLE_SEND_LIGHT;
    logic       long_hold_req  = 1'b0;
    logic       long_hold_done = 1'b0;
    int         hold_left      = 0;

    int fail_cnt  = 0;
    int quiet_cnt = 0;
    int lit_cnt   = 0;
    int op_cnt [4];
    int setting_cnt = 0;

    // ------------------------------------------------------------------
    // Pattern predictor: local copy of registers and sequencer state
    // ------------------------------------------------------------------
    lsbs_pkg::cfg_t   cfg_m;
    lsbs_pkg::mode_t  req_mode;
    lsbs_pkg::mode_t  saved_mode;
    lsbs_pkg::mode_t  run_mode;
    logic             override_on;
    lsbs_pkg::phase_t phase;
    logic [1:0]       pulse_idx;
    logic [15:0]      ticks_left;   // tick counter at the default 16-bit width
    logic             led_on;

    function automatic logic blinks(input lsbs_pkg::mode_t m);
        return (m == lsbs_pkg::MODE_STANDBY) || (m == lsbs_pkg::MODE_MEASURING);
    endfunction

    function automatic logic [15:0] half_len(input lsbs_pkg::mode_t m);
        return ((m == lsbs_pkg::MODE_STANDBY) ? cfg_m.standby_period
                                              : cfg_m.measuring_period) >> 1;
    endfunction

    // A zero duration still holds the phase for one tick. Registers are as wide
    // as the counter here, so the saturation case can never trigger.
    function automatic void load_phase(input lsbs_pkg::phase_t ph, input logic [15:0] dur,
                                       input logic lvl);
        phase      = ph;
        ticks_left = (dur == 16'd0) ? 16'd1 : dur;
        led_on     = lvl;
    endfunction

    function automatic void advance_pattern();
        logic [2:0] pulses;
        if (phase == lsbs_pkg::PH_START)
        begin
            // mode is only sampled when a new pattern begins
            run_mode  = req_mode;
            pulse_idx = 2'd0;
            load_phase(lsbs_pkg::PH_ON,
                       blinks(run_mode) ? half_len(run_mode) : cfg_m.pulse_on_ticks,
                       1'b1);
        end
        // the result of this tick shows the level left after its update
        ticks_left = ticks_left - 16'd1;
        if (ticks_left == 16'd0)
        begin
            case (phase)
                lsbs_pkg::PH_ON:
                begin
                    pulses = (run_mode == lsbs_pkg::MODE_LINK_LOST) ?
                             lsbs_pkg::PULSES_LINK_LOST : lsbs_pkg::PULSES_READING;
                    if (blinks(run_mode))
                        load_phase(lsbs_pkg::PH_OFF, half_len(run_mode), 1'b0);
                    else if ({1'b0, pulse_idx} + 3'd1 < pulses)
                        load_phase(lsbs_pkg::PH_GAP, cfg_m.pulse_gap_ticks, 1'b0);
                    else
                        load_phase(lsbs_pkg::PH_OFF, cfg_m.pattern_pause_ticks, 1'b0);
                end
                lsbs_pkg::PH_GAP:
                begin
                    pulse_idx = pulse_idx + 2'd1;
                    load_phase(lsbs_pkg::PH_ON, cfg_m.pulse_on_ticks, 1'b1);
                end
                default:
                begin
                    phase      = lsbs_pkg::PH_START;
                    pulse_idx  = 2'd0;
                    ticks_left = 16'd0;
                    led_on     = 1'b0;
                end
            endcase
        end
    endfunction

    function automatic led_status_t predict_status(input led_item_t it);
        led_status_t r;
        case (it.op)
            lsbs_pkg::OP_TICK:     advance_pattern();
            lsbs_pkg::OP_SET_MODE: req_mode = it.new_mode;   // override state untouched
            lsbs_pkg::OP_LINK_STATUS:
            begin
                if (!it.link_up)
                begin
                    // already in link-lost mode: nothing to save
                    if (req_mode != lsbs_pkg::MODE_LINK_LOST)
                    begin
                        saved_mode  = req_mode;
                        override_on = 1'b1;
                        req_mode    = lsbs_pkg::MODE_LINK_LOST;
                    end
                end
                else if (override_on)
                begin
                    override_on = 1'b0;
                    req_mode    = saved_mode;
                end
            end
            default: ;
        endcase
        r.led_primary   = led_on & cfg_m.builtin_enable;
        r.led_secondary = led_on & cfg_m.external_enable;
        r.mode_now      = req_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers items from item_q with random gaps
    // ------------------------------------------------------------------
    function automatic int sender_idle_pct();
        return (idle_plan == IDLE_SEND_LIGHT) ? 23 : (idle_plan == IDLE_SEND_HEAVY) ? 78 : 0;
    endfunction

    function automatic int receiver_idle_pct();
        return (idle_plan == IDLE_SEND_LIGHT) ? 78 : (idle_plan == IDLE_SEND_HEAVY) ? 23 : 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                void'(item_q.pop_front());
            // hold the current offer until it is taken
            if (!in_ch.valid || in_ch.ready)
            begin
                // a drain item waits until nothing is in flight
                if (item_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()
                    && !(item_q[0].drain && (in_ch.valid || status_q.size() != 0)))
                begin
                    in_ch.valid    <= 1'b1;
                    in_ch.op       <= item_q[0].op;
                    in_ch.new_mode <= item_q[0].new_mode;
                    in_ch.link_up  <= item_q[0].link_up;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else if (long_hold_req && !long_hold_done)
        begin
            hold_left      <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
            out_ch.ready   <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        led_item_t   it;
        led_status_t exp_st;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                it.op       = in_ch.op;
                it.new_mode = lsbs_pkg::mode_t'(in_ch.new_mode);
                it.link_up  = in_ch.link_up;
                it.drain    = 1'b0;
                op_cnt[it.op] = op_cnt[it.op] + 1;
                status_q.push_back(predict_status(it));
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (out_ch.led_primary || out_ch.led_secondary)
                    lit_cnt = lit_cnt + 1;
                if (status_q.size() == 0)
                begin
                    $error("result transfer with no prediction pending");
                    fail_cnt = fail_cnt + 1;
                end
                else
                begin
                    exp_st = status_q.pop_front();
                    if (out_ch.led_primary !== exp_st.led_primary)
                    begin
                        $error("led_primary: expected %0b, got %0b",
                               exp_st.led_primary, out_ch.led_primary);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (out_ch.led_secondary !== exp_st.led_secondary)
                    begin
                        $error("led_secondary: expected %0b, got %0b",
                               exp_st.led_secondary, out_ch.led_secondary);
                        fail_cnt = fail_cnt + 1;
                    end
                    if (out_ch.mode_now !== exp_st.mode_now)
                    begin
                        $error("mode_now: expected %0d, got %0d",
                               exp_st.mode_now, out_ch.mode_now);
                        fail_cnt = fail_cnt + 1;
                    end
                end
            end
            // watchdog: any transfer counts as progress
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cnt = 0;
            else
                quiet_cnt = quiet_cnt + 1;
            if (quiet_cnt >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("** led_status_blink_sequencer: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic [1:0] op, input lsbs_pkg::mode_t m,
                             input logic up);
        led_item_t it;
        it.op       = op;
        it.new_mode = m;
        it.link_up  = up;
        it.drain    = 1'b0;
        item_q.push_back(it);
    endtask

    // Mostly ticks so patterns run through, with mode changes and link
    // reports mixed in; don't-care fields are randomized too.
    function automatic led_item_t rand_item();
        led_item_t it;
        int        r;
        r = $urandom_range(99);
        if (r < 70)
            it.op = lsbs_pkg::OP_TICK;
        else if (r < 82)
            it.op = lsbs_pkg::OP_SET_MODE;
        else if (r < 94)
            it.op = lsbs_pkg::OP_LINK_STATUS;
        else
            it.op = OP_UNUSED;
        it.new_mode = lsbs_pkg::mode_t'($urandom_range(3));
        it.link_up  = 1'($urandom_range(1));
        it.drain    = 1'b0;
        return it;
    endfunction

    // Blocks until every queued item has been taken and every result is back
    task automatic wait_drained();
        while (item_q.size() != 0 || in_ch.valid || status_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write followed by a read-back; junk in the unused upper data bits
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] mask;
        mask = (idx == lsbs_pkg::REG_BUILTIN_ENABLE || idx == lsbs_pkg::REG_EXTERNAL_ENABLE) ?
               32'h1 : 32'hFFFF;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~mask) | ({16'd0, value} & mask);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // write lands on this edge
        case (idx)
            lsbs_pkg::REG_STANDBY_PERIOD:   cfg_m.standby_period      = value;
            lsbs_pkg::REG_MEASURING_PERIOD: cfg_m.measuring_period    = value;
            lsbs_pkg::REG_PULSE_ON:         cfg_m.pulse_on_ticks      = value;
            lsbs_pkg::REG_PULSE_GAP:        cfg_m.pulse_gap_ticks     = value;
            lsbs_pkg::REG_PATTERN_PAUSE:    cfg_m.pattern_pause_ticks = value;
            lsbs_pkg::REG_BUILTIN_ENABLE:   cfg_m.builtin_enable      = value[0];
            lsbs_pkg::REG_EXTERNAL_ENABLE:  cfg_m.external_enable     = value[0];
            default: ;
        endcase
        // psel stays high: straight into the read setup
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== ({16'd0, value} & mask))
        begin
            $error("register %0d read-back: expected %0h, got %0h",
                   idx, {16'd0, value} & mask, prdata & mask);
            fail_cnt = fail_cnt + 1;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain, reprogram all registers, then queue n non-ignored random items.
    // drain_at marks one item that must wait for an empty pipeline (-1: none).
    task automatic run_setting(input logic [15:0] sb_per, input logic [15:0] ms_per,
                               input logic [15:0] on_t, input logic [15:0] gap_t,
                               input logic [15:0] pause_t, input logic b_en,
                               input logic e_en, input idle_plan_t plan,
                               input int n_items, input int drain_at);
        led_item_t it;
        int        done;
        wait_drained();
        cfg_write(lsbs_pkg::REG_STANDBY_PERIOD, sb_per);
        cfg_write(lsbs_pkg::REG_MEASURING_PERIOD, ms_per);
        cfg_write(lsbs_pkg::REG_PULSE_ON, on_t);
        cfg_write(lsbs_pkg::REG_PULSE_GAP, gap_t);
        cfg_write(lsbs_pkg::REG_PATTERN_PAUSE, pause_t);
        cfg_write(lsbs_pkg::REG_BUILTIN_ENABLE, {15'd0, b_en});
        cfg_write(lsbs_pkg::REG_EXTERNAL_ENABLE, {15'd0, e_en});
        setting_cnt = setting_cnt + 1;
        idle_plan   = plan;
        done        = 0;
        while (done < n_items)
        begin
            it = rand_item();
            if (done == drain_at)
                it.drain = 1'b1;
            item_q.push_back(it);
            if (it.op != OP_UNUSED)
                done = done + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.op       = lsbs_pkg::OP_TICK;
        in_ch.new_mode = lsbs_pkg::MODE_STANDBY;
        in_ch.link_up  = 1'b1;
        out_ch.ready   = 1'b0;
        foreach (op_cnt[i])
            op_cnt[i] = 0;

        // predictor state after reset
        cfg_m = '{standby_period:      lsbs_pkg::RST_STANDBY_PERIOD,
                  measuring_period:    lsbs_pkg::RST_MEASURING_PERIOD,
                  pulse_on_ticks:      lsbs_pkg::RST_PULSE_ON,
                  pulse_gap_ticks:     lsbs_pkg::RST_PULSE_GAP,
                  pattern_pause_ticks: lsbs_pkg::RST_PATTERN_PAUSE,
                  builtin_enable:      lsbs_pkg::RST_BUILTIN_ENABLE,
                  external_enable:     lsbs_pkg::RST_EXTERNAL_ENABLE};
        req_mode    = lsbs_pkg::MODE_STANDBY;
        saved_mode  = lsbs_pkg::MODE_STANDBY;
        run_mode    = lsbs_pkg::MODE_STANDBY;
        override_on = 1'b0;
        phase       = lsbs_pkg::PH_START;
        pulse_idx   = 2'd0;
        ticks_left  = 16'd0;
        led_on      = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset defaults
        push_item(OP_UNUSED, lsbs_pkg::MODE_MEASURING, 1'b1);                // ignored op
        push_item(lsbs_pkg::OP_TICK, lsbs_pkg::MODE_STANDBY, 1'b0);          // starts lit
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_MEASURING, 1'b0);
        push_item(lsbs_pkg::OP_TICK, lsbs_pkg::MODE_STANDBY, 1'b0);
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_READING, 1'b1);
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_LINK_LOST, 1'b0);
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_STANDBY, 1'b1);
        // link up, no override
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_READING, 1'b1);
        // link lost saves standby
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_STANDBY, 1'b0);
        // lost again: no change
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_MEASURING, 1'b0);
        // mode set under override
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_READING, 1'b0);
        // lost while reading: resave
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_STANDBY, 1'b0);
        // restore
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_STANDBY, 1'b1);
        // up again: no change
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_LINK_LOST, 1'b1);
        push_item(lsbs_pkg::OP_SET_MODE, lsbs_pkg::MODE_LINK_LOST, 1'b1);
        // lost while link lost
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_STANDBY, 1'b0);
        // up without override
        push_item(lsbs_pkg::OP_LINK_STATUS, lsbs_pkg::MODE_STANDBY, 1'b1);
        push_item(OP_UNUSED, lsbs_pkg::MODE_MEASURING, 1'b0);
        repeat (6)
            push_item(lsbs_pkg::OP_TICK, lsbs_pkg::MODE_MEASURING, 1'b1);

        // short periods, both LEDs driven
        run_setting(16'd6, 16'd4, 16'd3, 16'd2, 16'd5, 1'b1, 1'b1,
                    IDLE_SEND_LIGHT, 400, -1);
        // zero and one: every phase collapses to a single tick
        run_setting(16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1,
                    IDLE_SEND_HEAVY, 300, -1);
        run_setting(16'd3, 16'd2, 16'd1, 16'd1, 16'd1, 1'b1, 1'b0,
                    IDLE_SEND_HEAVY, 300, -1);
        // odd periods; receiver stalls long while the sender keeps offering
        run_setting(16'd9, 16'd13, 16'd4, 16'd3, 16'd7, 1'b1, 1'b1,
                    IDLE_NONE, 350, 175);
        long_hold_req = 1'b1;
        // full-scale registers: patterns sit in one long phase
        run_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1,
                    IDLE_NONE, 100, -1);

        wait_drained();
        repeat (4) @(posedge clk);

        $display("covered %0d ticks, %0d mode sets, %0d link reports, %0d unused ops",
                 op_cnt[lsbs_pkg::OP_TICK], op_cnt[lsbs_pkg::OP_SET_MODE],
                 op_cnt[lsbs_pkg::OP_LINK_STATUS], op_cnt[OP_UNUSED]);
        $display("over %0d register settings plus defaults; %0d results with an LED lit",
                 setting_cnt, lit_cnt);
        if (fail_cnt == 0 && status_q.size() == 0)
            $display("** led_status_blink_sequencer: PASSED **");
        else
            $display("** led_status_blink_sequencer: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/lsbs_pkg.sv
rtl/lsbs_if.sv
rtl/lsbs_cfg_regs.sv
rtl/lsbs_core.sv
rtl/led_status_blink_sequencer.sv
test/tb_top.sv
